// File: sv/tos_pkg.sv
// Package for the timed output sequencer.
// Holds the item structs, the register index codes and the phase codes.
// No dependencies.
package tos_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE_MONOSTABLE = 2'd0;
  localparam logic [1:0] REG_DELAY_OR_PERIOD = 2'd1;
  localparam logic [1:0] REG_ACTIVE_OR_DUTY  = 2'd2;

  // Sequencer phase codes.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DELAY = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;
  localparam logic [1:0] PH_OFF   = 2'd3;

  // Width of the configuration data and of the configuration registers.
  localparam int CFG_BITS = 16;

  typedef struct packed {
    logic write_request;
    logic request_value;
    logic tick_elapsed;
  } tos_in_t;

  typedef struct packed {
    logic       output_level;
    logic [1:0] sequencer_state;
    logic       request_active;
  } tos_out_t;

endpackage

// File: sv/timed_output_sequencer.sv
// Timed output sequencer: delayed one-shot and periodic output channel.
// The result of a tick item is registered when the item is accepted.
// Throughput: one tick item per cycle; a full result register that is not
// taken holds off the next item. Reset clears the request latch, phase,
// timer, pin level, configuration registers and the result valid flag.
// Depends on tos_pkg.
module timed_output_sequencer
  import tos_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                tick_valid,
  output logic                tick_ready,
  input  tos_in_t             tick_item,
  output logic                res_valid,
  input  logic                res_ready,
  output tos_out_t            res_item
);

  // Configuration registers.
  logic                mode_monostable;
  logic [CFG_BITS-1:0] delay_or_period;
  logic [CFG_BITS-1:0] active_or_duty;

  // Channel state.
  logic                  request_latch;
  logic [1:0]            phase;
  logic [TIMER_BITS-1:0] countdown;
  logic                  pin_level;

  // Next state of the channel for the item at the input.
  logic                  request_next;
  logic [1:0]            phase_next;
  logic [TIMER_BITS-1:0] countdown_next;
  logic                  pin_next;

  // Timer load values, truncated or extended to the timer width.
  logic [31:0]           delay_wide;
  logic [31:0]           active_wide;
  logic [31:0]           gap_wide;
  logic [TIMER_BITS-1:0] delay_load;
  logic [TIMER_BITS-1:0] active_load;
  logic [TIMER_BITS-1:0] gap_load;

  logic tick_accept;

  assign cfg_ready   = 1'b1;
  assign tick_ready  = !rst && (!res_valid || res_ready);
  assign tick_accept = tick_valid && tick_ready;

  assign delay_wide  = 32'(delay_or_period);
  assign active_wide = 32'(active_or_duty);
  assign gap_wide    = delay_wide - active_wide;
  assign delay_load  = delay_wide[TIMER_BITS-1:0];
  assign active_load = active_wide[TIMER_BITS-1:0];
  assign gap_load    = gap_wide[TIMER_BITS-1:0];

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_monostable <= 1'b0;
      delay_or_period <= '0;
      active_or_duty  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE_MONOSTABLE: mode_monostable <= cfg_data[0];
        REG_DELAY_OR_PERIOD: delay_or_period <= cfg_data;
        REG_ACTIVE_OR_DUTY:  active_or_duty  <= cfg_data;
        default: ;
      endcase
    end
  end

  // One evaluation step: latch write, timer tick, then the phase logic.
  always_comb begin
    logic go;
    request_next   = tick_item.write_request ? tick_item.request_value : request_latch;
    countdown_next = (tick_item.tick_elapsed && countdown != '0) ?
                     countdown - TIMER_BITS'(1) : countdown;
    phase_next     = phase;
    pin_next       = pin_level;
    go             = 1'b1;

    if (!request_next) begin
      // A cleared request drops the pin and returns to idle.
      pin_next       = 1'b0;
      countdown_next = '0;
      phase_next     = PH_IDLE;
    end else if (mode_monostable) begin
      // Delayed one-shot.
      if (phase_next == PH_IDLE) begin
        if (delay_or_period != '0) begin
          countdown_next = delay_load;
          phase_next     = PH_DELAY;
        end
      end else if (phase_next != PH_DELAY && phase_next != PH_HOLD) begin
        go = 1'b0;
      end
      if (go && phase_next != PH_HOLD) begin
        if (countdown_next != '0) begin
          go = 1'b0;
        end else begin
          pin_next = 1'b1;
          if (active_or_duty != '0) begin
            countdown_next = active_load;
            phase_next     = PH_HOLD;
          end else begin
            phase_next = PH_IDLE;
            go         = 1'b0;
          end
        end
      end
      if (go && countdown_next == '0) begin
        request_next = 1'b0;
        phase_next   = PH_IDLE;
      end
    end else begin
      // Periodic duty cycle.
      if (phase_next == PH_IDLE) begin
        if (countdown_next != '0) begin
          go = 1'b0;
        end else begin
          pin_next = 1'b1;
          if (active_or_duty >= delay_or_period) begin
            go = 1'b0;
          end else begin
            countdown_next = active_load;
            phase_next     = PH_OFF;
          end
        end
      end else if (phase_next != PH_OFF) begin
        go = 1'b0;
      end
      if (go && countdown_next == '0) begin
        pin_next       = 1'b0;
        countdown_next = gap_load;
        phase_next     = PH_IDLE;
      end
    end
  end

  // Channel state and the result register advance together on each item.
  always_ff @(posedge clk) begin
    if (rst) begin
      request_latch <= 1'b0;
      phase         <= PH_IDLE;
      countdown     <= '0;
      pin_level     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (tick_accept) begin
        request_latch <= request_next;
        phase         <= phase_next;
        countdown     <= countdown_next;
        pin_level     <= pin_next;
        res_valid     <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      res_item.output_level    <= pin_next;
      res_item.sequencer_state <= phase_next;
      res_item.request_active  <= request_next;
    end
  end

endmodule

// File: sv/tos_checker.sv
// Port-level checker for the timed output sequencer, bound to the top level.
// Depends on tos_pkg and on timed_output_sequencer.
module tos_checker
  import tos_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     tick_valid,
  input logic     tick_ready,
  input tos_in_t  tick_item,
  input logic     res_valid,
  input logic     res_ready,
  input tos_out_t res_item
);

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // An empty result register never holds off an item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> tick_ready)
    else $error("input stalled with empty result register");

  // An item that clears the request gives an idle, low result.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready && tick_item.write_request && !tick_item.request_value
    |=> res_valid && !res_item.request_active && !res_item.output_level &&
        res_item.sequencer_state == PH_IDLE)
    else $error("request clear did not idle the channel");

  // A high pin with the request cleared happens only at the end of a hold.
  a_hold_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.request_active && res_item.output_level
    |-> res_item.sequencer_state == PH_IDLE)
    else $error("high pin without request outside idle");

endmodule

bind timed_output_sequencer tos_checker u_tos_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick_valid),
  .tick_ready (tick_ready),
  .tick_item  (tick_item),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res_item   (res_item)
);
